/* rtl/core/aes128_ofb_stream_cipher_defines.svh */
// ----------------------------------------------------------------------------
// AES-128 OFB stream cipher assertion macros
// Assertion helpers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef AES128_OFB_STREAM_CIPHER_DEFINES_SVH
`define AES128_OFB_STREAM_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS
`define AOFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define AOFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AOFB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AOFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/aofb_pkg.sv */
// ----------------------------------------------------------------------------
// AES-128 OFB package
// Shared types, constants and AES round functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aofb_pkg;

	localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
	localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
	localparam logic [1:0] CFG_IV_HIGH  = 2'd2;
	localparam logic [1:0] CFG_IV_LOW   = 2'd3;
	localparam int CFG_IDX_W = 2;
	localparam int ROUNDS = 10;

	typedef struct packed {
		logic start;
		logic load_iv;
		logic round;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic last_round;
	} dp_stat_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] r;
		case (a)
8'h00:r=8'h63;8'h01:r=8'h7c;8'h02:r=8'h77;8'h03:r=8'h7b;8'h04:r=8'hf2;8'h05:r=8'h6b;8'h06:r=8'h6f;8'h07:r=8'hc5;
8'h08:r=8'h30;8'h09:r=8'h01;8'h0a:r=8'h67;8'h0b:r=8'h2b;8'h0c:r=8'hfe;8'h0d:r=8'hd7;8'h0e:r=8'hab;8'h0f:r=8'h76;
8'h10:r=8'hca;8'h11:r=8'h82;8'h12:r=8'hc9;8'h13:r=8'h7d;8'h14:r=8'hfa;8'h15:r=8'h59;8'h16:r=8'h47;8'h17:r=8'hf0;
8'h18:r=8'had;8'h19:r=8'hd4;8'h1a:r=8'ha2;8'h1b:r=8'haf;8'h1c:r=8'h9c;8'h1d:r=8'ha4;8'h1e:r=8'h72;8'h1f:r=8'hc0;
8'h20:r=8'hb7;8'h21:r=8'hfd;8'h22:r=8'h93;8'h23:r=8'h26;8'h24:r=8'h36;8'h25:r=8'h3f;8'h26:r=8'hf7;8'h27:r=8'hcc;
8'h28:r=8'h34;8'h29:r=8'ha5;8'h2a:r=8'he5;8'h2b:r=8'hf1;8'h2c:r=8'h71;8'h2d:r=8'hd8;8'h2e:r=8'h31;8'h2f:r=8'h15;
8'h30:r=8'h04;8'h31:r=8'hc7;8'h32:r=8'h23;8'h33:r=8'hc3;8'h34:r=8'h18;8'h35:r=8'h96;8'h36:r=8'h05;8'h37:r=8'h9a;
8'h38:r=8'h07;8'h39:r=8'h12;8'h3a:r=8'h80;8'h3b:r=8'he2;8'h3c:r=8'heb;8'h3d:r=8'h27;8'h3e:r=8'hb2;8'h3f:r=8'h75;
8'h40:r=8'h09;8'h41:r=8'h83;8'h42:r=8'h2c;8'h43:r=8'h1a;8'h44:r=8'h1b;8'h45:r=8'h6e;8'h46:r=8'h5a;8'h47:r=8'ha0;
8'h48:r=8'h52;8'h49:r=8'h3b;8'h4a:r=8'hd6;8'h4b:r=8'hb3;8'h4c:r=8'h29;8'h4d:r=8'he3;8'h4e:r=8'h2f;8'h4f:r=8'h84;
8'h50:r=8'h53;8'h51:r=8'hd1;8'h52:r=8'h00;8'h53:r=8'hed;8'h54:r=8'h20;8'h55:r=8'hfc;8'h56:r=8'hb1;8'h57:r=8'h5b;
8'h58:r=8'h6a;8'h59:r=8'hcb;8'h5a:r=8'hbe;8'h5b:r=8'h39;8'h5c:r=8'h4a;8'h5d:r=8'h4c;8'h5e:r=8'h58;8'h5f:r=8'hcf;
8'h60:r=8'hd0;8'h61:r=8'hef;8'h62:r=8'haa;8'h63:r=8'hfb;8'h64:r=8'h43;8'h65:r=8'h4d;8'h66:r=8'h33;8'h67:r=8'h85;
8'h68:r=8'h45;8'h69:r=8'hf9;8'h6a:r=8'h02;8'h6b:r=8'h7f;8'h6c:r=8'h50;8'h6d:r=8'h3c;8'h6e:r=8'h9f;8'h6f:r=8'ha8;
8'h70:r=8'h51;8'h71:r=8'ha3;8'h72:r=8'h40;8'h73:r=8'h8f;8'h74:r=8'h92;8'h75:r=8'h9d;8'h76:r=8'h38;8'h77:r=8'hf5;
8'h78:r=8'hbc;8'h79:r=8'hb6;8'h7a:r=8'hda;8'h7b:r=8'h21;8'h7c:r=8'h10;8'h7d:r=8'hff;8'h7e:r=8'hf3;8'h7f:r=8'hd2;
8'h80:r=8'hcd;8'h81:r=8'h0c;8'h82:r=8'h13;8'h83:r=8'hec;8'h84:r=8'h5f;8'h85:r=8'h97;8'h86:r=8'h44;8'h87:r=8'h17;
8'h88:r=8'hc4;8'h89:r=8'ha7;8'h8a:r=8'h7e;8'h8b:r=8'h3d;8'h8c:r=8'h64;8'h8d:r=8'h5d;8'h8e:r=8'h19;8'h8f:r=8'h73;
8'h90:r=8'h60;8'h91:r=8'h81;8'h92:r=8'h4f;8'h93:r=8'hdc;8'h94:r=8'h22;8'h95:r=8'h2a;8'h96:r=8'h90;8'h97:r=8'h88;
8'h98:r=8'h46;8'h99:r=8'hee;8'h9a:r=8'hb8;8'h9b:r=8'h14;8'h9c:r=8'hde;8'h9d:r=8'h5e;8'h9e:r=8'h0b;8'h9f:r=8'hdb;
8'ha0:r=8'he0;8'ha1:r=8'h32;8'ha2:r=8'h3a;8'ha3:r=8'h0a;8'ha4:r=8'h49;8'ha5:r=8'h06;8'ha6:r=8'h24;8'ha7:r=8'h5c;
8'ha8:r=8'hc2;8'ha9:r=8'hd3;8'haa:r=8'hac;8'hab:r=8'h62;8'hac:r=8'h91;8'had:r=8'h95;8'hae:r=8'he4;8'haf:r=8'h79;
8'hb0:r=8'he7;8'hb1:r=8'hc8;8'hb2:r=8'h37;8'hb3:r=8'h6d;8'hb4:r=8'h8d;8'hb5:r=8'hd5;8'hb6:r=8'h4e;8'hb7:r=8'ha9;
8'hb8:r=8'h6c;8'hb9:r=8'h56;8'hba:r=8'hf4;8'hbb:r=8'hea;8'hbc:r=8'h65;8'hbd:r=8'h7a;8'hbe:r=8'hae;8'hbf:r=8'h08;
8'hc0:r=8'hba;8'hc1:r=8'h78;8'hc2:r=8'h25;8'hc3:r=8'h2e;8'hc4:r=8'h1c;8'hc5:r=8'ha6;8'hc6:r=8'hb4;8'hc7:r=8'hc6;
8'hc8:r=8'he8;8'hc9:r=8'hdd;8'hca:r=8'h74;8'hcb:r=8'h1f;8'hcc:r=8'h4b;8'hcd:r=8'hbd;8'hce:r=8'h8b;8'hcf:r=8'h8a;
8'hd0:r=8'h70;8'hd1:r=8'h3e;8'hd2:r=8'hb5;8'hd3:r=8'h66;8'hd4:r=8'h48;8'hd5:r=8'h03;8'hd6:r=8'hf6;8'hd7:r=8'h0e;
8'hd8:r=8'h61;8'hd9:r=8'h35;8'hda:r=8'h57;8'hdb:r=8'hb9;8'hdc:r=8'h86;8'hdd:r=8'hc1;8'hde:r=8'h1d;8'hdf:r=8'h9e;
8'he0:r=8'he1;8'he1:r=8'hf8;8'he2:r=8'h98;8'he3:r=8'h11;8'he4:r=8'h69;8'he5:r=8'hd9;8'he6:r=8'h8e;8'he7:r=8'h94;
8'he8:r=8'h9b;8'he9:r=8'h1e;8'hea:r=8'h87;8'heb:r=8'he9;8'hec:r=8'hce;8'hed:r=8'h55;8'hee:r=8'h28;8'hef:r=8'hdf;
8'hf0:r=8'h8c;8'hf1:r=8'ha1;8'hf2:r=8'h89;8'hf3:r=8'h0d;8'hf4:r=8'hbf;8'hf5:r=8'he6;8'hf6:r=8'h42;8'hf7:r=8'h68;
8'hf8:r=8'h41;8'hf9:r=8'h99;8'hfa:r=8'h2d;8'hfb:r=8'h0f;8'hfc:r=8'hb0;8'hfd:r=8'h54;8'hfe:r=8'hbb;8'hff:r=8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of a block sits at bits 127-8i
	function automatic logic [7:0] blk_byte(input logic [127:0] b, input int i);
		return b[127 - 8 * i -: 8];
	endfunction

	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
		logic [7:0] kb [16];
		logic [7:0] t [4];
		logic [127:0] r;
		for (int i = 0; i < 16; i++) kb[i] = blk_byte(k, i);
		t[0] = sbox(kb[13]) ^ rc;
		t[1] = sbox(kb[14]);
		t[2] = sbox(kb[15]);
		t[3] = sbox(kb[12]);
		for (int i = 0; i < 16; i++) begin
			kb[i] = kb[i] ^ ((i < 4) ? t[i] : kb[i - 4]);
		end
		for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = kb[i];
		return r;
	endfunction

	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
		logic [7:0] sb [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) sb[i] = blk_byte(s, i);
		for (int rr = 0; rr < 4; rr++)
			for (int c = 0; c < 4; c++)
				t[rr + 4 * c] = sbox(sb[rr + 4 * ((c + rr) & 3)]);
		for (int c = 0; c < 4; c++) begin
			a0 = t[4 * c];
			a1 = t[4 * c + 1];
			a2 = t[4 * c + 2];
			a3 = t[4 * c + 3];
			al = a0 ^ a1 ^ a2 ^ a3;
			if (last) begin
				sb[4 * c] = a0;
				sb[4 * c + 1] = a1;
				sb[4 * c + 2] = a2;
				sb[4 * c + 3] = a3;
			end else begin
				sb[4 * c]     = a0 ^ al ^ xtime(a0 ^ a1);
				sb[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
				sb[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
				sb[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = sb[i];
		return r;
	endfunction

endpackage

/* rtl/core/aes128_ofb_stream_cipher.sv */
// ----------------------------------------------------------------------------
// AES-128 OFB stream cipher
// Byte-wide output-feedback keystream cipher built on one AES round per cycle.
// ----------------------------------------------------------------------------
// channel   signals                                       handshake
// cfg       cfg_we, cfg_index, cfg_data                   write enable
// in        in_valid, in_ready, data_byte, end_of_message valid/ready
// out       out_valid, out_ready, out_byte, last_out      valid/ready
//
// Bytes within a block are accepted while the output register is free; a byte
// opening a new 16-byte block waits for the state load and ten AES rounds.
// Reset clears configuration to zero and restarts the message from the IV.
// The output register holds a result while out_ready is low; input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aes128_ofb_stream_cipher_defines.svh"

module aes128_ofb_stream_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_out
);

	aofb_pkg::dp_cmd_t  cmd;
	aofb_pkg::dp_stat_t stat;
	logic [7:0] res;
	logic gen_busy;

	aofb_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .end_of_message,
		.out_valid, .out_ready, .cmd, .stat, .gen_busy
	);

	aofb_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cmd, .stat,
		.data_byte, .ks_byte(res)
	);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			out_byte <= res;
			last_out <= end_of_message;
		end
	end

	`AOFB_ASSERT_IMPL(a_no_accept_gen, clk, arst_n, gen_busy, !in_ready)
	`AOFB_ASSERT_NEXT(a_out_after_acc, clk, arst_n, in_valid && in_ready, out_valid)
	`AOFB_ASSERT_IMPL(a_stall_blocks, clk, arst_n, out_valid && !out_ready, !in_ready)

endmodule

/* rtl/core/aofb_datapath.sv */
// ----------------------------------------------------------------------------
// AES-128 OFB datapath
// Key and IV registers, round state, key schedule, byte position and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aofb_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aofb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	input  aofb_pkg::dp_cmd_t             cmd,
	output aofb_pkg::dp_stat_t            stat,
	input  logic [7:0]                    data_byte,
	output logic [7:0]                    ks_byte
);

	logic [63:0]  key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic [127:0] state_q, rkey_q, ks_q;
	logic [7:0]   rc_q;
	logic [3:0]   round_q;
	logic [3:0]   pos_q;
	logic [127:0] nk, ns;

	assign nk = aofb_pkg::next_key(rkey_q, rc_q);
	assign ns = aofb_pkg::enc_round(state_q, round_q == 4'(aofb_pkg::ROUNDS)) ^ nk;
	assign stat.last_round = (round_q == 4'(aofb_pkg::ROUNDS));
	assign ks_byte = ks_q[127 - 8 * pos_q[3:0] -: 8] ^ data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				aofb_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data;
				aofb_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data;
				aofb_pkg::CFG_IV_HIGH:  iv_high_q  <= cfg_data;
				aofb_pkg::CFG_IV_LOW:   iv_low_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
			pos_q   <= '0;
		end else begin
			if (cmd.start) round_q <= 4'd1;
			else if (cmd.round) round_q <= round_q + 4'd1;
			if (cmd.finish) pos_q <= cmd.load_iv ? 4'd0 : pos_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			state_q <= (cmd.load_iv ? {iv_high_q, iv_low_q} : ks_q) ^ {key_high_q, key_low_q};
			rkey_q  <= {key_high_q, key_low_q};
			rc_q    <= 8'h01;
		end else if (cmd.round) begin
			state_q <= ns;
			rkey_q  <= nk;
			rc_q    <= aofb_pkg::xtime(rc_q);
			if (stat.last_round) ks_q <= ns;
		end
	end

endmodule

/* rtl/core/aofb_ctrl.sv */
// ----------------------------------------------------------------------------
// AES-128 OFB controller
// Sequences keystream generation and the byte handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aofb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                end_of_message,
	output logic                out_valid,
	input  logic                out_ready,
	output aofb_pkg::dp_cmd_t   cmd,
	input  aofb_pkg::dp_stat_t  stat,
	output logic                gen_busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GEN  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0] state_q;
	logic       msg_start_q;
	logic [3:0] cnt_q;
	logic       acc;

	assign in_ready = (state_q == ST_OUT) && (!out_valid || out_ready);
	assign acc = in_valid && in_ready;
	assign gen_busy = (state_q == ST_GEN);

	always_comb begin
		cmd = '0;
		cmd.start = (state_q == ST_IDLE) && in_valid;
		cmd.load_iv = msg_start_q;
		cmd.round = (state_q == ST_GEN);
		cmd.finish = acc;
		if (acc) cmd.load_iv = end_of_message;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			msg_start_q <= 1'b1;
			cnt_q       <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_GEN;
				ST_GEN: if (stat.last_round) begin
					state_q     <= ST_OUT;
					msg_start_q <= 1'b0;
					cnt_q       <= '0;
				end
				ST_OUT: if (acc) begin
					out_valid <= 1'b1;
					cnt_q <= cnt_q + 4'd1;
					if (end_of_message) begin
						msg_start_q <= 1'b1;
						state_q <= ST_IDLE;
					end else if (cnt_q == 4'd15) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* bench/aes128_ofb_stream_cipher_test.sv */
// ----------------------------------------------------------------------------
// AES-128 OFB stream cipher testbench
// Drives bytes with random idling on both sides (off in the last run) and
// compares every output item to an in-bench AES-128 OFB keystream predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes128_ofb_stream_cipher_test;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} cipher_item_t;

	localparam int CYCLE_LIMIT = 900000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        end_of_message;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        last_out;

	aes128_ofb_stream_cipher uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .end_of_message(end_of_message),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
		.last_out(last_out)
	);

	logic [127:0] cipher_key;
	logic [127:0] init_vector;
	logic [127:0] feedback;
	logic [127:0] keystream;
	logic [3:0]   byte_pos;
	logic         msg_start;

	cipher_item_t expected_bytes[$];
	int           error_count;
	bit           sink_idle_on;
	bit           src_idle_on;
	longint       cycle_count;

	localparam logic [7:0] SBOX_TAB [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] gf_double(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] aes_block(input logic [127:0] pt, input logic [127:0] key);
		logic [7:0] s [16];
		logic [7:0] k [16];
		logic [7:0] t [16];
		logic [7:0] w [4];
		logic [7:0] rc;
		logic [7:0] all;
		logic [127:0] r;
		rc = 8'h01;
		for (int i = 0; i < 16; i++) begin
			s[i] = pt[127 - 8 * i -: 8] ^ key[127 - 8 * i -: 8];
			k[i] = key[127 - 8 * i -: 8];
		end
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int rr = 0; rr < 4; rr++)
				for (int c = 0; c < 4; c++)
					t[rr + 4 * c] = SBOX_TAB[s[rr + 4 * ((c + rr) & 3)]];
			for (int c = 0; c < 4; c++) begin
				all = t[4 * c] ^ t[4 * c + 1] ^ t[4 * c + 2] ^ t[4 * c + 3];
				for (int j = 0; j < 4; j++) begin
					if (rnd < 10) begin
						s[4 * c + j] = t[4 * c + j] ^ all
							^ gf_double(t[4 * c + j] ^ t[4 * c + ((j + 1) & 3)]);
					end else begin
						s[4 * c + j] = t[4 * c + j];
					end
				end
			end
			w[0] = SBOX_TAB[k[13]] ^ rc;
			w[1] = SBOX_TAB[k[14]];
			w[2] = SBOX_TAB[k[15]];
			w[3] = SBOX_TAB[k[12]];
			for (int i = 0; i < 16; i++) k[i] = k[i] ^ ((i < 4) ? w[i] : k[i - 4]);
			rc = gf_double(rc);
			for (int i = 0; i < 16; i++) s[i] = s[i] ^ k[i];
		end
		for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = s[i];
		return r;
	endfunction

	function automatic cipher_item_t ofb_transform(input cipher_item_t it);
		cipher_item_t res;
		if (msg_start) begin
			feedback = init_vector;
			byte_pos = 4'd0;
			msg_start = 1'b0;
		end
		if (byte_pos == 4'd0) begin
			keystream = aes_block(feedback, cipher_key);
			feedback = keystream;
		end
		res.data = it.data ^ keystream[127 - 8 * byte_pos -: 8];
		res.last = it.last;
		byte_pos = byte_pos + 4'd1;
		if (it.last) begin
			msg_start = 1'b1;
			byte_pos = 4'd0;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch %s: got %02h expected %02h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout");
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// sink idling
	int sink_gap;
	always @(posedge clk) begin
		if (arst_n) begin
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				out_ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				sink_gap <= $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// check each output item
	always @(posedge clk) begin
		cipher_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected item", out_byte, 8'h00);
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
				if (last_out !== want.last)
					report_mismatch("last_out", {7'd0, last_out}, {7'd0, want.last});
			end
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic eom);
		cipher_item_t it;
		int gap;
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.data = d;
		it.last = eom;
		in_valid <= 1'b1;
		data_byte <= d;
		end_of_message <= eom;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_bytes.push_back(ofb_transform(it));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			aofb_pkg::CFG_KEY_HIGH: cipher_key[127:64] = val;
			aofb_pkg::CFG_KEY_LOW:  cipher_key[63:0] = val;
			aofb_pkg::CFG_IV_HIGH:  init_vector[127:64] = val;
			default:                init_vector[63:0] = val;
		endcase
		@(posedge clk);
	endtask

	task automatic set_all_regs(input logic [127:0] k, input logic [127:0] v);
		write_reg(aofb_pkg::CFG_KEY_HIGH, k[127:64]);
		write_reg(aofb_pkg::CFG_KEY_LOW, k[63:0]);
		write_reg(aofb_pkg::CFG_IV_HIGH, v[127:64]);
		write_reg(aofb_pkg::CFG_IV_LOW, v[63:0]);
	endtask

	task automatic send_message(input int len, input bit end_it);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), end_it && (i == len - 1));
	endtask

	task automatic test_reset_defaults();
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_message(15, 1'b1);
		wait_drained();
	endtask

	task automatic test_directed_extremes();
		set_all_regs({128{1'b1}}, {128{1'b1}});
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		send_message(17, 1'b1);
		wait_drained();
		set_all_regs(128'h2b7e151628aed2a6abf7158809cf4f3c,
			128'h000102030405060708090a0b0c0d0e0f);
		send_message(5, 1'b1);
		wait_drained();
	endtask

	task automatic test_mid_message_writes();
		send_message(20, 1'b0);
		wait_drained();
		// new key applies at the next block, new IV at the next message
		write_reg(aofb_pkg::CFG_KEY_LOW, {$urandom, $urandom});
		write_reg(aofb_pkg::CFG_IV_HIGH, {$urandom, $urandom});
		send_message(14, 1'b1);
		send_message(3, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_messages(input int total, input bit idle);
		int sent;
		int len;
		sent = 0;
		src_idle_on = idle;
		sink_idle_on = idle;
		while (sent < total) begin
			if ($urandom_range(0, 9) == 0) begin
				wait_drained();
				set_all_regs({$urandom, $urandom, $urandom, $urandom},
					{$urandom, $urandom, $urandom, $urandom});
			end
			case ($urandom_range(0, 3))
				0: len = $urandom_range(1, 4);
				1: len = 16 * $urandom_range(1, 3);
				default: len = $urandom_range(1, 50);
			endcase
			send_message(len, $urandom_range(0, 7) != 0);
			sent += len;
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = aofb_pkg::CFG_KEY_HIGH;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		end_of_message = 1'b0;
		out_ready = 1'b0;
		sink_gap = 0;
		cycle_count = 0;
		error_count = 0;
		sink_idle_on = 1'b1;
		src_idle_on = 1'b1;
		cipher_key = '0;
		init_vector = '0;
		feedback = '0;
		keystream = '0;
		byte_pos = 4'd0;
		msg_start = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_extremes();
		test_mid_message_writes();
		test_random_messages(1500, 1'b1);
		test_random_messages(300, 1'b0);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/aofb_pkg.sv
rtl/core/aofb_datapath.sv
rtl/core/aofb_ctrl.sv
rtl/core/aes128_ofb_stream_cipher.sv
bench/aes128_ofb_stream_cipher_test.sv
